// ===== sv/bgr_pkg.sv =====
package bgr_pkg;

    // Fixed field widths
    localparam int MAX_GLYPH_WIDTH = 16;
    localparam int ADDRESS_BITS    = 24;
    localparam int ROW_W           = MAX_GLYPH_WIDTH;
    localparam int ROWNUM_W        = 6;
    localparam int OFFSET_W        = 16;
    localparam int ORIGIN_W        = 12;
    localparam int GWIDTH_W        = 5;
    localparam int GHEIGHT_W       = 7;
    localparam int STRIDE_W        = 13;
    localparam int COLOR_W         = 16;
    localparam int PIX_ADDR_W      = 24;
    localparam int CFG_DATA_W      = 13;
    localparam int CFG_IDX_W       = 3;
    localparam int COL_IDX_W       = $clog2(MAX_GLYPH_WIDTH);

    // Line index: origin_y + line_offset + row_number
    localparam int LINE_W     = 17;
    // Column base: origin_x + column_offset
    localparam int XBASE_W    = 17;
    // Line times stride
    localparam int PROD_W     = LINE_W + STRIDE_W;
    // Full address before truncation
    localparam int FULL_ADDR_W = PROD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_GLYPH_WIDTH  = 3'd2,
        REG_GLYPH_HEIGHT = 3'd3,
        REG_SCREEN_WIDTH = 3'd4,
        REG_COLOR_RED    = 3'd5,
        REG_COLOR_GREEN  = 3'd6,
        REG_COLOR_BLUE   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0]  origin_x;
        logic [ORIGIN_W-1:0]  origin_y;
        logic [GWIDTH_W-1:0]  glyph_width;
        logic [GHEIGHT_W-1:0] glyph_height;
        logic [STRIDE_W-1:0]  screen_width;
        logic [COLOR_W-1:0]   color;
    } cfg_t;

    // One glyph row ready for scanning; leftmost pixel sits in the top bit
    typedef struct packed {
        logic [ROW_W-1:0]   bits;
        logic [LINE_W-1:0]  line;
        logic [XBASE_W-1:0] xbase;
    } row_job_t;

    // Cursor advance after a glyph: w - w/5 for w up to 16
    function automatic logic [GWIDTH_W-1:0] glyph_advance(input logic [GWIDTH_W-1:0] w);
        logic [GWIDTH_W-1:0] q;
        begin
            case (w)
                5'd0, 5'd1, 5'd2, 5'd3, 5'd4:       q = 5'd0;
                5'd5, 5'd6, 5'd7, 5'd8, 5'd9:       q = 5'd1;
                5'd10, 5'd11, 5'd12, 5'd13, 5'd14:  q = 5'd2;
                default:                            q = 5'd3;
            endcase
            glyph_advance = w - q;
        end
    endfunction

    // Column of the leftmost set bit (top bit is column zero)
    function automatic logic [COL_IDX_W-1:0] first_column(input logic [ROW_W-1:0] bits);
        logic [COL_IDX_W-1:0] idx;
        begin
            idx = '0;
            for (int k = 0; k < ROW_W; k++)
            begin
                if (bits[k])
                begin
                    idx = COL_IDX_W'(ROW_W - 1 - k);
                end
            end
            first_column = idx;
        end
    endfunction

endpackage

// ===== sv/bgr_if.sv =====
interface glyph_row_if import bgr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ROW_W-1:0]    row_bits;
    logic [ROWNUM_W-1:0] row_number;
    logic                final_row;
    logic                is_newline;
    logic                string_start;

    modport source (output valid, row_bits, row_number, final_row, is_newline,
                    string_start, input ready);
    modport sink (input valid, row_bits, row_number, final_row, is_newline,
                  string_start, output ready);
endinterface

interface pixel_if import bgr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIX_ADDR_W-1:0] pixel_address;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last_pixel;
    logic                  out_of_range;

    modport source (output valid, pixel_address, pixel_color, last_pixel, out_of_range,
                    input ready);
    modport sink (input valid, pixel_address, pixel_color, last_pixel, out_of_range,
                  output ready);
endinterface

// ===== sv/bgr_front.sv =====
module bgr_front
    import bgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    glyph_row_if.sink  glyphs,
    input  logic       job_full,
    output logic       job_push,
    output row_job_t   job
);

    logic [OFFSET_W-1:0] column_offset_reg, column_offset_next;
    logic [OFFSET_W-1:0] line_offset_reg, line_offset_next;
    logic [OFFSET_W-1:0] col_cur, line_cur;
    logic [GWIDTH_W-1:0] eff_w;
    logic [ROW_W:0]      width_mask;
    logic [ROW_W-1:0]    masked_bits;
    logic                accept;

    assign glyphs.ready = !job_full;
    assign accept       = glyphs.valid && glyphs.ready;

    // Saturate the cell width to the widest supported glyph
    assign eff_w = (cfg.glyph_width > GWIDTH_W'(MAX_GLYPH_WIDTH)) ? GWIDTH_W'(MAX_GLYPH_WIDTH)
                                                                  : cfg.glyph_width;

    // Offsets as seen by this word, after a string start
    assign col_cur  = glyphs.string_start ? '0 : column_offset_reg;
    assign line_cur = glyphs.string_start ? '0 : line_offset_reg;

    // Keep the used bits and left-align them
    assign width_mask  = (ROW_W+1)'(1) << eff_w;
    assign masked_bits = glyphs.row_bits & ROW_W'(width_mask - (ROW_W+1)'(1));

    always_comb
    begin
        job.bits  = ROW_W'(masked_bits << (GWIDTH_W'(ROW_W) - eff_w));
        job.line  = LINE_W'(cfg.origin_y) + LINE_W'(line_cur) + LINE_W'(glyphs.row_number);
        job.xbase = XBASE_W'(cfg.origin_x) + XBASE_W'(col_cur);
    end

    // Drop newlines and empty rows; only rows with pixels go to the queue
    assign job_push = accept && !glyphs.is_newline && (masked_bits != '0);

    // Advance the cursor
    always_comb
    begin
        column_offset_next = column_offset_reg;
        line_offset_next   = line_offset_reg;
        if (accept)
        begin
            if (glyphs.is_newline)
            begin
                column_offset_next = '0;
                line_offset_next   = line_cur + OFFSET_W'(cfg.glyph_height);
            end
            else
            begin
                line_offset_next = line_cur;
                if (glyphs.final_row)
                begin
                    column_offset_next = col_cur + OFFSET_W'(glyph_advance(eff_w));
                end
                else
                begin
                    column_offset_next = col_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= '0;
            line_offset_reg   <= '0;
        end
        else
        begin
            column_offset_reg <= column_offset_next;
            line_offset_reg   <= line_offset_next;
        end
    end

endmodule

// ===== sv/bgr_queue.sv =====
module bgr_queue
    import bgr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  row_job_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     pop_valid,
    output row_job_t pop_data
);

    localparam int DEPTH = 2;

    row_job_t         entry_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == 2'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/bgr_back.sv =====
module bgr_back
    import bgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    input  row_job_t  job,
    output logic      job_pop,
    pixel_if.source   pixels
);

    // Multiply stage
    logic                  m_valid_reg;
    logic [PROD_W-1:0]     m_prod_reg;
    logic [XBASE_W-1:0]    m_xbase_reg;
    logic [ROW_W-1:0]      m_bits_reg;

    // Scan stage
    logic                  s_valid_reg, s_valid_next;
    logic [FULL_ADDR_W-1:0] s_base_reg;
    logic [ROW_W-1:0]      s_bits_reg, s_bits_next;

    // Output word
    logic                  o_valid_reg, o_valid_next;
    logic [PIX_ADDR_W-1:0] o_addr_reg;
    logic                  o_last_reg;
    logic                  o_oor_reg;

    logic                  out_free, scan_fire, scan_done, s_free, s_load, m_free;
    logic [COL_IDX_W-1:0]  col;
    logic [ROW_W-1:0]      bits_left;
    logic [FULL_ADDR_W-1:0] full_addr;

    assign out_free  = !o_valid_reg || pixels.ready;
    assign col       = first_column(s_bits_reg);
    assign bits_left = s_bits_reg & ~(ROW_W'(1) << (COL_IDX_W'(ROW_W - 1) - col));
    assign full_addr = s_base_reg + FULL_ADDR_W'(col);

    assign scan_fire = s_valid_reg && out_free;
    assign scan_done = scan_fire && (bits_left == '0);
    assign s_free    = !s_valid_reg || scan_done;
    assign s_load    = m_valid_reg && s_free;
    assign m_free    = !m_valid_reg || s_load;
    assign job_pop   = job_valid && m_free;

    always_comb
    begin
        s_bits_next  = s_bits_reg;
        s_valid_next = s_valid_reg;
        if (s_load)
        begin
            s_bits_next  = m_bits_reg;
            s_valid_next = 1'b1;
        end
        else if (scan_fire)
        begin
            s_bits_next  = bits_left;
            s_valid_next = !scan_done;
        end
        o_valid_next = o_valid_reg;
        if (scan_fire)
        begin
            o_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            m_prod_reg  <= PROD_W'(job.line) * PROD_W'(cfg.screen_width);
            m_xbase_reg <= job.xbase;
            m_bits_reg  <= job.bits;
        end
        if (s_load)
        begin
            s_base_reg <= FULL_ADDR_W'(m_prod_reg) + FULL_ADDR_W'(m_xbase_reg);
        end
        s_bits_reg <= s_bits_next;
        if (scan_fire)
        begin
            o_addr_reg <= full_addr[PIX_ADDR_W-1:0];
            o_oor_reg  <= (full_addr[FULL_ADDR_W-1:ADDRESS_BITS] != '0);
            o_last_reg <= (bits_left == '0);
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_free)
            begin
                m_valid_reg <= job_valid;
            end
            s_valid_reg <= s_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign pixels.valid         = o_valid_reg;
    assign pixels.pixel_address = o_addr_reg;
    assign pixels.pixel_color   = cfg.color;
    assign pixels.last_pixel    = o_last_reg;
    assign pixels.out_of_range  = o_oor_reg;

endmodule

// ===== sv/bitmap_glyph_text_rasterizer.sv =====
// Path: an accepted glyph row passes the row queue, then the multiply, scan and output
// registers, and its first pixel word is then offered on the pixel interface.
// Throughput: one pixel word per cycle while the receiver is ready; a row yields one word
// per set bit, and newline and empty rows are taken at the input and emit nothing.
// The input side runs ahead of the scan unit by a two-entry row queue.
// Reset: configuration registers take their default values, cursor offsets clear, queue and stages empty.
module bitmap_glyph_text_rasterizer
    import bgr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    glyph_row_if.sink             glyphs,
    pixel_if.source               pixels
);

    logic [ORIGIN_W-1:0]  origin_x_reg;
    logic [ORIGIN_W-1:0]  origin_y_reg;
    logic [GWIDTH_W-1:0]  glyph_width_reg;
    logic [GHEIGHT_W-1:0] glyph_height_reg;
    logic [STRIDE_W-1:0]  screen_width_reg;
    logic [4:0]           color_red_reg;
    logic [5:0]           color_green_reg;
    logic [4:0]           color_blue_reg;

    cfg_t     cfg;
    logic     job_full, job_push, job_pop, job_valid;
    row_job_t job_in, job_out;

    // Register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            glyph_width_reg  <= 5'd8;
            glyph_height_reg <= 7'd16;
            screen_width_reg <= 13'd640;
            color_red_reg    <= 5'd31;
            color_green_reg  <= 6'd63;
            color_blue_reg   <= 5'd31;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_ORIGIN_X:     origin_x_reg     <= wr_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= wr_data[ORIGIN_W-1:0];
                REG_GLYPH_WIDTH:  glyph_width_reg  <= wr_data[GWIDTH_W-1:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= wr_data[GHEIGHT_W-1:0];
                REG_SCREEN_WIDTH: screen_width_reg <= wr_data[STRIDE_W-1:0];
                REG_COLOR_RED:    color_red_reg    <= wr_data[4:0];
                REG_COLOR_GREEN:  color_green_reg  <= wr_data[5:0];
                REG_COLOR_BLUE:   color_blue_reg   <= wr_data[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.origin_x     = origin_x_reg;
        cfg.origin_y     = origin_y_reg;
        cfg.glyph_width  = glyph_width_reg;
        cfg.glyph_height = glyph_height_reg;
        cfg.screen_width = screen_width_reg;
        cfg.color        = {color_red_reg, color_green_reg, color_blue_reg};
    end

    bgr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .glyphs   (glyphs),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    bgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_valid (job_valid),
        .pop_data  (job_out)
    );

    bgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .pixels    (pixels)
    );

endmodule

// ===== tb/bitmap_glyph_text_rasterizer_tb.sv =====
module bitmap_glyph_text_rasterizer_tb;
    import bgr_pkg::*;

    localparam int RESET_CYCLES      = 12;
    // multiply, scan and output stages plus a two-entry row queue, with margin
    localparam int SETTLE_CYCLES     = 16;
    localparam int HOLD_CYCLES       = 300;
    // longest quiet stretch is the forced receiver hold-off plus a settle
    localparam int QUIET_LIMIT       = 4000;
    localparam int PHASES            = 5;
    localparam int PHASE_WORDS       = 42;
    localparam int NEWLINE_RUN_WORDS = 12;
    localparam int EMPTY_RUN_WORDS   = 12;
    localparam int ADVANCE_DIV       = 5;
    localparam logic [63:0] STORE_SIZE = 64'd1 << ADDRESS_BITS;

    typedef struct packed {
        logic [ROW_W-1:0]    bits;
        logic [ROWNUM_W-1:0] row;
        logic                final_row;
        logic                newline;
        logic                start;
    } glyph_word_t;

    typedef struct packed {
        logic [PIX_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]    color;
        logic                  last;
        logic                  oor;
    } pixel_word_t;

    typedef enum logic {STEP_WORD, STEP_REG} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        cfg_index_t            reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        glyph_word_t           word;
        logic                  typed;
        pixel_word_t           px;
    } plan_step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    glyph_row_if glyphs();
    pixel_if     pixels();

    bitmap_glyph_text_rasterizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .glyphs   (glyphs),
        .pixels   (pixels)
    );

    // Raster state mirrored from the block
    logic [ORIGIN_W-1:0]  org_x;
    logic [ORIGIN_W-1:0]  org_y;
    logic [GWIDTH_W-1:0]  cell_w;
    logic [GHEIGHT_W-1:0] cell_h;
    logic [STRIDE_W-1:0]  stride;
    logic [4:0]           red;
    logic [5:0]           green;
    logic [4:0]           blue;
    logic [OFFSET_W-1:0]  col_ofs;
    logic [OFFSET_W-1:0]  line_ofs;

    pixel_word_t pending_pixels[$];
    plan_step_t  directed_plan[$];
    pixel_word_t head_px;
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          src_idle_on = 1'b0;
    bit          sink_idle_on = 1'b0;
    bit          hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic glyph_word_t make_word(input logic [ROW_W-1:0] bits,
                                              input logic [ROWNUM_W-1:0] row,
                                              input logic fin, input logic nl,
                                              input logic st);
        glyph_word_t w;
        w.bits      = bits;
        w.row       = row;
        w.final_row = fin;
        w.newline   = nl;
        w.start     = st;
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] random_bits();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return ROW_W'($urandom);
        endcase
    endfunction

    task automatic plan_word(input glyph_word_t w, input logic typed,
                             input logic [PIX_ADDR_W-1:0] addr,
                             input logic [COLOR_W-1:0] color, input logic oor);
        plan_step_t s;
        s          = '0;
        s.kind     = STEP_WORD;
        s.word     = w;
        s.typed    = typed;
        s.px.addr  = addr;
        s.px.color = color;
        s.px.last  = 1'b1;
        s.px.oor   = oor;
        directed_plan.push_back(s);
    endtask

    task automatic plan_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        plan_step_t s;
        s          = '0;
        s.kind     = STEP_REG;
        s.reg_idx  = idx;
        s.reg_data = data;
        directed_plan.push_back(s);
    endtask

    // Scan one glyph row, update the cursor, queue the pixel words it yields if keep is set
    task automatic rasterize_row(input glyph_word_t w, input bit keep);
        logic [GWIDTH_W-1:0] eff;
        logic [63:0]         line;
        logic [63:0]         full;
        pixel_word_t         px;
        int                  last_i;
        int                  i;
        eff = (cell_w > MAX_GLYPH_WIDTH) ? GWIDTH_W'(MAX_GLYPH_WIDTH) : cell_w;
        if (w.start)
        begin
            col_ofs  = '0;
            line_ofs = '0;
        end
        if (w.newline)
        begin
            col_ofs  = '0;
            line_ofs = line_ofs + cell_h;
            return;
        end
        line   = 64'(org_y) + 64'(line_ofs) + 64'(w.row);
        last_i = -1;
        for (i = 0; i < eff; i++)
        begin
            if (w.bits[eff - 1 - i])
                last_i = i;
        end
        for (i = 0; i < eff; i++)
        begin
            if (w.bits[eff - 1 - i] && keep)
            begin
                full     = line * 64'(stride) + 64'(org_x) + 64'(col_ofs) + 64'(i);
                px.addr  = full[PIX_ADDR_W-1:0];
                px.color = {red, green, blue};
                px.last  = (i == last_i);
                px.oor   = (full >= STORE_SIZE);
                pending_pixels.push_back(px);
            end
        end
        if (w.final_row)
            col_ofs = col_ofs + OFFSET_W'(eff - eff / ADVANCE_DIV);
    endtask

    // Drive one register write; the caller drops wr_en after the batch
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_ORIGIN_X:     org_x  = data[ORIGIN_W-1:0];
            REG_ORIGIN_Y:     org_y  = data[ORIGIN_W-1:0];
            REG_GLYPH_WIDTH:  cell_w = data[GWIDTH_W-1:0];
            REG_GLYPH_HEIGHT: cell_h = data[GHEIGHT_W-1:0];
            REG_SCREEN_WIDTH: stride = data[STRIDE_W-1:0];
            REG_COLOR_RED:    red    = data[4:0];
            REG_COLOR_GREEN:  green  = data[5:0];
            REG_COLOR_BLUE:   blue   = data[4:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid, wait for every pending pixel, then let the pipeline empty
    task automatic settle();
        glyphs.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy,
                                  input logic [GWIDTH_W-1:0] gw, input logic [GHEIGHT_W-1:0] gh,
                                  input logic [STRIDE_W-1:0] sw, input logic [4:0] r,
                                  input logic [5:0] g, input logic [4:0] b);
        settle();
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
        write_reg(REG_GLYPH_WIDTH, CFG_DATA_W'(gw));
        write_reg(REG_GLYPH_HEIGHT, CFG_DATA_W'(gh));
        write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(sw));
        write_reg(REG_COLOR_RED, CFG_DATA_W'(r));
        write_reg(REG_COLOR_GREEN, CFG_DATA_W'(g));
        write_reg(REG_COLOR_BLUE, CFG_DATA_W'(b));
        wr_en <= 1'b0;
    endtask

    // Offer one glyph word, hold it until taken, then predict its pixels
    task automatic send_word(input glyph_word_t w, input logic typed, input pixel_word_t typed_px);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            glyphs.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        glyphs.valid        <= 1'b1;
        glyphs.row_bits     <= w.bits;
        glyphs.row_number   <= w.row;
        glyphs.final_row    <= w.final_row;
        glyphs.is_newline   <= w.newline;
        glyphs.string_start <= w.start;
        @(posedge clk);
        while (!glyphs.ready)
            @(posedge clk);
        if (typed)
        begin
            rasterize_row(w, 1'b0);
            pending_pixels.push_back(typed_px);
        end
        else
        begin
            rasterize_row(w, 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each pixel word against the oldest prediction; track quiet cycles
    always @(posedge clk)
    begin
        if ((glyphs.valid && glyphs.ready) || (pixels.valid && pixels.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (pixels.valid && pixels.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel word with nothing pending: pixel_address %0h",
                       pixels.pixel_address);
                error_count++;
            end
            else
            begin
                head_px = pending_pixels.pop_front();
                check_field("pixel_address", 32'(head_px.addr), 32'(pixels.pixel_address));
                check_field("pixel_color", 32'(head_px.color), 32'(pixels.pixel_color));
                check_field("last_pixel", 32'(head_px.last), 32'(pixels.last_pixel));
                check_field("out_of_range", 32'(head_px.oor), 32'(pixels.out_of_range));
            end
        end
    end

    // Pixel receiver: random stalls, plus one long hold-off on request
    initial
    begin
        pixels.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pixels.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                pixels.ready <= 1'b1;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                pixels.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                pixels.ready <= 1'b1;
            end
            else
            begin
                pixels.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int          sent;
        int          rows;
        int          choice;
        int          p;
        int          r;
        glyph_word_t w;
        step_kind_t  prev_kind;

        rst_n               <= 1'b0;
        wr_en               <= 1'b0;
        wr_index            <= REG_ORIGIN_X;
        wr_data             <= '0;
        glyphs.valid        <= 1'b0;
        glyphs.row_bits     <= '0;
        glyphs.row_number   <= '0;
        glyphs.final_row    <= 1'b0;
        glyphs.is_newline   <= 1'b0;
        glyphs.string_start <= 1'b0;

        // Power-on register values and a cleared cursor
        org_x    = '0;
        org_y    = '0;
        cell_w   = 5'd8;
        cell_h   = 7'd16;
        stride   = 13'd640;
        red      = 5'd31;
        green    = 6'd63;
        blue     = 5'd31;
        col_ofs  = '0;
        line_ofs = '0;

        // Defaults: leftmost pixel, bottom row right pixel, full row, junk newline, empty row
        plan_word(make_word(16'h0080, 6'd0, 1'b0, 1'b0, 1'b0), 1'b1, 24'd0, 16'hFFFF, 1'b0);
        plan_word(make_word(16'h0001, 6'd63, 1'b1, 1'b0, 1'b0), 1'b1, 24'd40327, 16'hFFFF,
                  1'b0);
        plan_word(make_word(16'hFFFF, 6'd0, 1'b0, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'h5A5A, 6'd2, 1'b1, 1'b1, 1'b0), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'h00FF, 6'd1, 1'b1, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'h0000, 6'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'h0080, 6'd0, 1'b0, 1'b0, 1'b1), 1'b1, 24'd0, 16'hFFFF, 1'b0);
        // Extremes: far origin, oversized glyph width, widest stride, black
        plan_reg(REG_ORIGIN_X, 13'd4095);
        plan_reg(REG_ORIGIN_Y, 13'd4095);
        plan_reg(REG_GLYPH_WIDTH, 13'd31);
        plan_reg(REG_GLYPH_HEIGHT, 13'd127);
        plan_reg(REG_SCREEN_WIDTH, 13'd8191);
        plan_reg(REG_COLOR_RED, 13'd0);
        plan_reg(REG_COLOR_GREEN, 13'd0);
        plan_reg(REG_COLOR_BLUE, 13'd0);
        plan_word(make_word(16'h8000, 6'd0, 1'b0, 1'b0, 1'b1), 1'b1, 24'd16769024, 16'h0000,
                  1'b1);
        plan_word(make_word(16'hFFFF, 6'd63, 1'b1, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'hFFFF, 6'd63, 1'b1, 1'b1, 1'b1), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'hAAAA, 6'd5, 1'b1, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        // Zero glyph width: no pixels, no advance
        plan_reg(REG_GLYPH_WIDTH, 13'd0);
        plan_word(make_word(16'hFFFF, 6'd1, 1'b1, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        // Single-pixel glyph with zero stride, magenta
        plan_reg(REG_GLYPH_WIDTH, 13'd1);
        plan_reg(REG_SCREEN_WIDTH, 13'd0);
        plan_reg(REG_COLOR_RED, 13'd31);
        plan_reg(REG_COLOR_BLUE, 13'd31);
        plan_word(make_word(16'h0001, 6'd10, 1'b1, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'hFFFE, 6'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);
        // Full-width rows at the top-left, unit stride
        plan_reg(REG_GLYPH_WIDTH, 13'd16);
        plan_reg(REG_SCREEN_WIDTH, 13'd1);
        plan_reg(REG_ORIGIN_X, 13'd0);
        plan_reg(REG_ORIGIN_Y, 13'd0);
        plan_word(make_word(16'hFFFF, 6'd63, 1'b1, 1'b0, 1'b1), 1'b0, '0, '0, 1'b0);
        plan_word(make_word(16'h8001, 6'd0, 1'b0, 1'b0, 1'b0), 1'b0, '0, '0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        prev_kind    = STEP_WORD;
        foreach (directed_plan[k])
        begin
            if (directed_plan[k].kind == STEP_REG)
            begin
                if (prev_kind == STEP_WORD)
                    settle();
                write_reg(directed_plan[k].reg_idx, directed_plan[k].reg_data);
            end
            else
            begin
                wr_en <= 1'b0;
                send_word(directed_plan[k].word, directed_plan[k].typed, directed_plan[k].px);
            end
            prev_kind = directed_plan[k].kind;
        end

        // Run tall newlines back to back, then a string of empty glyphs
        apply_settings(12'd17, 12'd3, 5'd16, 7'd127, 13'd640, 5'd12, 6'd40, 5'd7);
        src_idle_on = 1'b0;
        repeat (NEWLINE_RUN_WORDS)
        begin
            w = make_word(random_bits(), ROWNUM_W'($urandom), 1'($urandom), 1'b1, 1'b0);
            send_word(w, 1'b0, '0);
        end
        send_word(make_word(16'hFFFF, 6'd2, 1'b0, 1'b0, 1'b0), 1'b0, '0);
        repeat (EMPTY_RUN_WORDS)
            send_word(make_word(16'h0000, 6'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0);
        send_word(make_word(16'hC003, 6'd1, 1'b1, 1'b0, 1'b0), 1'b0, '0);

        // Random phases: mostly whole glyphs, some newlines, broken glyphs and noise
        for (p = 0; p < PHASES; p++)
        begin
            apply_settings(ORIGIN_W'($urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, 63)),
                           ORIGIN_W'($urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                          : $urandom_range(0, 63)),
                           GWIDTH_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                                 : $urandom_range(1, 16)),
                           GHEIGHT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                                  : $urandom_range(1, 16)),
                           STRIDE_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                                 : $urandom_range(1, 4096)),
                           5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                           5'($urandom_range(0, 31)));
            src_idle_on  = (p < PHASES - 1) && (p == 0 || $urandom_range(0, 3) != 0);
            sink_idle_on = (p < PHASES - 1) && (p == 0 || $urandom_range(0, 3) != 0);
            if (p == 1)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                choice = $urandom_range(0, 9);
                if (choice == 0)
                begin
                    w = make_word(ROW_W'($urandom), ROWNUM_W'($urandom), 1'($urandom),
                                  1'($urandom), 1'($urandom));
                    send_word(w, 1'b0, '0);
                    sent++;
                end
                else if (choice == 1)
                begin
                    w = make_word(random_bits(), ROWNUM_W'($urandom), 1'($urandom), 1'b1,
                                  1'($urandom_range(0, 7) == 0));
                    send_word(w, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // Choice two drops the closing row flag
                    rows = $urandom_range(1, 8);
                    for (r = 0; r < rows; r++)
                    begin
                        w = make_word(random_bits(), ROWNUM_W'(r),
                                      (r == rows - 1) && (choice != 2), 1'b0,
                                      (r == 0) && ($urandom_range(0, 7) == 0));
                        send_word(w, 1'b0, '0);
                    end
                    sent += rows;
                end
            end
        end

        settle();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
